FILE: rtl/fast_pkg.sv
`default_nettype none
package fast_pkg;

  localparam int unsigned FreqW  = 33;
  localparam int unsigned CountW = 24;
  localparam int unsigned SumW   = 40;
  localparam int unsigned DbW    = 16;
  localparam int unsigned TolW   = 27;
  localparam int unsigned PctW   = 14;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CfgW   = 27;
  localparam int unsigned IdxW   = 6;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CountW-1:0] HitScale = 24'd10000;

  typedef enum logic [StatW-1:0] {
    StMerged  = 3'd0,
    StCreated = 3'd1,
    StFull    = 3'd2,
    StNoEntry = 3'd3,
    StReadOk  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CfgTol  = 2'd0,
    CfgHits = 2'd1,
    CfgPct  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FsIdle,
    FsSearch,
    FsUpdate,
    FsMul,
    FsEmit
  } fsm_e;

  typedef struct packed {
    logic [FreqW-1:0]  center;
    logic [CountW-1:0] checks;
    logic [CountW-1:0] hits;
    logic [SumW-1:0]   snr_sum;
    logic [SumW-1:0]   act_sum;
    logic [DbW-1:0]    snr_max;
    logic [DbW-1:0]    snr_min;
    logic [FreqW-1:0]  best_freq;
    logic [DbW-1:0]    best_power;
    logic [DbW-1:0]    best_noise;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  function automatic logic [CountW-1:0] cnt_inc(input logic [CountW-1:0] c);
    cnt_inc = (c == CountMax) ? c : c + 1'b1;
  endfunction

  function automatic logic [SumW-1:0] sum_sat(input logic [SumW-1:0] a,
                                              input logic [DbW-1:0] b);
    logic [SumW:0] r;
    r = {a[SumW-1], a} + {{(SumW-DbW+1){b[DbW-1]}}, b};
    if (r[SumW] != r[SumW-1]) begin
      sum_sat = r[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = r[SumW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fast_ram.sv
`default_nettype none
module fast_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/frequency_activity_stats_table_unit.sv
// Keeps up to TABLE_ENTRIES frequency entries in one synchronous RAM, one entry
// per word. A record item walks the entries in creation order, one RAM read per
// cycle, and merges into the first entry within tolerance, else creates an entry
// after the stored ones, else reports the table full; a merge or a creation
// writes the entry back. A read item reads the entry at its index, or reports no
// entry when the index is not below the entry count. The single result strobe
// (valid_o) is shown for one cycle in the last busy cycle; the receiver cannot
// stall. The next item is accepted only while busy is low. The pass check
// uses one registered multiply stage.
`default_nettype none
module frequency_activity_stats_table_unit
  import fast_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               kind_i,
  input  wire logic [FreqW-1:0]   target_freq_hz_i,
  input  wire logic [FreqW-1:0]   peak_freq_hz_i,
  input  wire logic signed [DbW-1:0] snr_centi_db_i,
  input  wire logic signed [DbW-1:0] power_centi_db_i,
  input  wire logic signed [DbW-1:0] noise_centi_db_i,
  input  wire logic               is_active_i,
  input  wire logic [IdxW-1:0]    read_index_i,
  output logic                    valid_o,
  output logic [FreqW-1:0]        center_freq_hz_o,
  output logic [StatW-1:0]        status_o,
  output logic [CountW-1:0]       check_count_o,
  output logic [CountW-1:0]       hit_count_o,
  output logic signed [SumW-1:0]  snr_total_o,
  output logic signed [SumW-1:0]  active_snr_total_o,
  output logic signed [DbW-1:0]   snr_peak_o,
  output logic signed [DbW-1:0]   snr_floor_o,
  output logic [FreqW-1:0]        best_freq_hz_o,
  output logic signed [DbW-1:0]   best_power_centi_db_o,
  output logic signed [DbW-1:0]   best_noise_centi_db_o,
  output logic                    passes_filter_o
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] Full = CW'(TABLE_ENTRIES);

  logic [TolW-1:0]   tol_q;
  logic [CountW-1:0] min_hits_q;
  logic [PctW-1:0]   min_pct_q;

  fsm_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          kind_q, act_q;
  logic [FreqW-1:0] tgt_q, peak_q;
  logic [DbW-1:0] snr_q, pwr_q, noi_q;
  logic [IdxW-1:0] ridx_q;
  entry_t res_q, res_d;
  status_e st_q, st_d;
  logic [CountW+14-1:0] lhs_q, rhs_q;
  logic          vld_q, vld_d;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;
  logic rd_pend_q, rd_pend_d;

  fast_ram #(.Width(EntryW), .Depth(TABLE_ENTRIES)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= TolW'(1);
      min_hits_q <= '0;
      min_pct_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTol:  tol_q      <= cfg_data_i[TolW-1:0];
        CfgHits: min_hits_q <= cfg_data_i[CountW-1:0];
        CfgPct:  min_pct_q  <= cfg_data_i[PctW-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  logic [FreqW-1:0] span;
  logic hit_match;
  entry_t upd;

  always_comb begin
    span = (ram_rdata.center >= tgt_q) ? ram_rdata.center - tgt_q
                                       : tgt_q - ram_rdata.center;
    hit_match = span <= FreqW'(tol_q);
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    res_d     = res_q;
    st_d      = st_q;
    vld_d     = 1'b0;
    rd_pend_d = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0];
    ram_raddr = ptr_q[AW-1:0];
    ram_wdata = res_q;
    upd       = ram_rdata;
    unique case (state_q)
      FsIdle: begin
        if (accept) begin
          if (kind_i) begin
            ptr_d = CW'(read_index_i);
            state_d = FsSearch;
          end else begin
            ptr_d = '0;
            state_d = FsSearch;
          end
          rd_pend_d = 1'b0;
        end
      end
      FsSearch: begin
        // a read is valid next cycle, when rd_pend_q; that data is for ptr_q
        if (kind_q) begin
          if (!rd_pend_q) begin
            if (32'(ridx_q) < 32'(count_q)) begin
              rd_pend_d = 1'b1;
            end else begin
              res_d = '0;
              st_d = StNoEntry;
              state_d = FsMul;
            end
          end else begin
            res_d = ram_rdata;
            st_d = StReadOk;
            state_d = FsMul;
          end
        end else if (rd_pend_q && hit_match) begin
          upd.checks  = cnt_inc(ram_rdata.checks);
          upd.snr_sum = sum_sat(ram_rdata.snr_sum, snr_q);
          if ($signed(snr_q) > $signed(ram_rdata.snr_max)) begin
            upd.snr_max    = snr_q;
            upd.best_freq  = peak_q;
            upd.best_power = pwr_q;
            upd.best_noise = noi_q;
          end
          if ($signed(snr_q) < $signed(ram_rdata.snr_min)) begin
            upd.snr_min = snr_q;
          end
          res_d = upd;
          st_d = StMerged;
          state_d = FsUpdate;
        end else begin
          if (ptr_q + CW'(rd_pend_q) >= count_q && (rd_pend_q || ptr_q >= count_q)) begin
            if (count_q == Full) begin
              res_d = '0;
              res_d.center = tgt_q;
              st_d = StFull;
              state_d = FsMul;
            end else begin
              res_d.center     = tgt_q;
              res_d.checks     = CountW'(1);
              res_d.hits       = '0;
              res_d.snr_sum    = {{(SumW-DbW){snr_q[DbW-1]}}, snr_q};
              res_d.act_sum    = '0;
              res_d.snr_max    = snr_q;
              res_d.snr_min    = snr_q;
              res_d.best_freq  = peak_q;
              res_d.best_power = pwr_q;
              res_d.best_noise = noi_q;
              ptr_d = count_q;
              count_d = count_q + 1'b1;
              st_d = StCreated;
              state_d = FsUpdate;
            end
          end else begin
            if (rd_pend_q) begin
              ptr_d = ptr_q + 1'b1;
            end
            rd_pend_d = 1'b1;
          end
        end
        if (!kind_q && rd_pend_q) begin
          ram_raddr = ptr_q[AW-1:0] + 1'b1;
        end
        if (kind_q) begin
          ram_raddr = AW'(ridx_q);
        end
      end
      FsUpdate: begin
        if (act_q) begin
          res_d.hits    = cnt_inc(res_q.hits);
          res_d.act_sum = sum_sat(res_q.act_sum, snr_q);
        end
        ram_we = 1'b1;
        ram_wdata = res_d;
        state_d = FsMul;
      end
      FsMul: begin
        state_d = FsEmit;
        vld_d = 1'b1;
      end
      FsEmit: begin
        state_d = FsIdle;
      end
      default: state_d = FsIdle;
    endcase
  end

  // the search loop uses ptr_q as "address of data arriving now"
  // when a read is pending; on first cycle pointer 0 read is issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FsIdle;
      count_q   <= '0;
      ptr_q     <= '0;
      vld_q     <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      vld_q     <= vld_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      act_q  <= is_active_i;
      tgt_q  <= target_freq_hz_i;
      peak_q <= peak_freq_hz_i;
      snr_q  <= snr_centi_db_i;
      pwr_q  <= power_centi_db_i;
      noi_q  <= noise_centi_db_i;
      ridx_q <= read_index_i;
    end
    res_q <= res_d;
    st_q  <= st_d;
    lhs_q <= (res_d.checks == '0) ? '0 : res_d.hits * HitScale;
    rhs_q <= CountW'(min_pct_q) * res_d.checks;
  end

  logic pass;
  assign pass = (res_q.hits >= min_hits_q) && (lhs_q >= rhs_q);

  logic pass_q;
  always_ff @(posedge clk_i) begin
    pass_q <= pass && (st_q == StMerged || st_q == StCreated || st_q == StReadOk);
  end

  assign busy                  = (state_q != FsIdle);
  assign valid_o               = vld_q;
  assign center_freq_hz_o      = res_q.center;
  assign status_o              = st_q;
  assign check_count_o         = res_q.checks;
  assign hit_count_o           = res_q.hits;
  assign snr_total_o           = res_q.snr_sum;
  assign active_snr_total_o    = res_q.act_sum;
  assign snr_peak_o            = res_q.snr_max;
  assign snr_floor_o           = res_q.snr_min;
  assign best_freq_hz_o        = res_q.best_freq;
  assign best_power_centi_db_o = res_q.best_power;
  assign best_noise_centi_db_o = res_q.best_noise;
  assign passes_filter_o       = pass_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= Full)
    else $error("entry count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> busy)
    else $error("result outside item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> CW'(ram_waddr) < count_q || count_q == Full)
    else $error("write past table");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !valid_o)
    else $error("result too early");

endmodule
`default_nettype wire
